FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the core modules.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: rtl/core/clnw_pkg.sv
package clnw_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_INSTR  = 3'd1;
    localparam logic [2:0] CMD_CHAR   = 3'd2;
    localparam logic [2:0] CMD_CURSOR = 3'd3;
    localparam logic [2:0] CMD_UDEC   = 3'd4;
    localparam logic [2:0] CMD_SDEC   = 3'd5;
    localparam logic [2:0] CMD_HEX    = 3'd6;

    localparam logic [3:0]  INIT_STEP_LAST = 4'd14;
    localparam logic [14:0] BYTE_WAIT_US   = 15'd50;
    localparam logic [15:0] DIV10_MUL      = 16'hCCCD;
    localparam logic [7:0]  CHAR_MINUS     = 8'h2D;
    localparam logic [7:0]  CHAR_SPACE     = 8'h20;
    localparam logic [7:0]  CURSOR_BASE    = 8'h80;

    typedef struct packed {
        logic       init;
        logic       rs;
        logic [7:0] data;
        logic       last;
    } clnw_entry_t;

    typedef struct packed {
        logic        kind;
        logic        reg_select;
        logic [3:0]  nibble;
        logic [14:0] wait_after_us;
        logic        last;
    } clnw_xfer_t;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = 8'd48 + {4'h0, d};
        end
        else
        begin
            c = 8'd55 + {4'h0, d};
        end
        return c;
    endfunction

    function automatic clnw_xfer_t init_step(input logic [3:0] idx);
        clnw_xfer_t x;
        x.kind          = 1'b0;
        x.reg_select    = 1'b0;
        x.nibble        = 4'h0;
        x.wait_after_us = 15'd0;
        x.last          = 1'b0;
        unique case (idx) inside
            4'd0:
            begin
                x.kind          = 1'b1;
                x.reg_select    = 1'b1;
                x.nibble        = 4'hF;
                x.wait_after_us = 15'd20000;
            end
            4'd1:
            begin
                x.nibble        = 4'h3;
                x.wait_after_us = 15'd15000;
            end
            4'd2, 4'd3:
            begin
                x.nibble        = 4'h3;
                x.wait_after_us = 15'd5000;
            end
            4'd4:
            begin
                x.nibble        = 4'h2;
                x.wait_after_us = 15'd5000;
            end
            4'd5:  x.nibble = 4'h2;
            4'd6:
            begin
                x.nibble        = 4'h8;
                x.wait_after_us = BYTE_WAIT_US + 15'd1000;
            end
            4'd7:  x.nibble = 4'h0;
            4'd8:
            begin
                x.nibble        = 4'hC;
                x.wait_after_us = BYTE_WAIT_US + 15'd1000;
            end
            4'd9:  x.nibble = 4'h0;
            4'd10:
            begin
                x.nibble        = 4'h6;
                x.wait_after_us = BYTE_WAIT_US + 15'd1000;
            end
            4'd11: x.nibble = 4'h0;
            4'd12:
            begin
                x.nibble        = 4'h1;
                x.wait_after_us = BYTE_WAIT_US + 15'd2000;
            end
            4'd13: x.nibble = 4'h8;
            4'd14:
            begin
                x.nibble        = 4'h0;
                x.wait_after_us = BYTE_WAIT_US + 15'd2000;
            end
            default: x.nibble = 4'h0;
        endcase
        return x;
    endfunction

endpackage

FILE: rtl/core/clnw_if.sv
interface clnw_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [15:0] value;
    logic        row;
    logic [5:0]  col;

    modport source (output valid, cmd, value, row, col, input ready);
    modport sink (input valid, cmd, value, row, col, output ready);
endinterface

interface clnw_xfer_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [14:0] wait_after_us;
    logic        last;

    modport source (output valid, kind, reg_select, nibble, wait_after_us, last, input ready);
    modport sink (input valid, kind, reg_select, nibble, wait_after_us, last, output ready);
endinterface

FILE: rtl/core/clnw_front.sv
`include "assert_macros.svh"

module clnw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    clnw_cmd_if.sink             cmds,
    output logic                 q_valid,
    input  logic                 q_ready,
    output clnw_pkg::clnw_entry_t q_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;
    localparam int SLOTS = 6;

    logic [1:0]  state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  steps_reg, steps_next;
    logic [15:0] val_reg, val_next;
    logic        hex_reg, hex_next;
    logic        sign_reg, sign_next;
    logic        neg_reg, neg_next;
    logic        init_reg, init_next;
    logic        rs_reg, rs_next;
    logic [7:0]  chr_reg [SLOTS];
    logic [7:0]  chr_next [SLOTS];

    logic [31:0] prod;
    logic [12:0] quot;
    logic [15:0] ten_q;
    logic [15:0] diff;
    logic [7:0]  conv_char;
    logic [15:0] conv_val;
    logic [6:0]  cursor_addr;
    logic        take;

    assign prod        = 32'(val_reg) * 32'(clnw_pkg::DIV10_MUL);
    assign quot        = prod[31:19];
    assign ten_q       = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign diff        = val_reg - ten_q;
    assign conv_char   = hex_reg ? clnw_pkg::hex_char(val_reg[3:0]) : {4'h3, diff[3:0]};
    assign conv_val    = hex_reg ? {4'h0, val_reg[15:4]} : {3'b000, quot};
    assign cursor_addr = {cmds.row, 6'b000000} + {1'b0, cmds.col};

    assign cmds.ready = (state_reg == ST_IDLE) ||
                        ((state_reg == ST_EMIT) && (cnt_reg == 3'd1) && q_ready);
    assign take       = cmds.valid && cmds.ready;

    assign q_valid      = (state_reg == ST_EMIT);
    assign q_data.init  = init_reg;
    assign q_data.rs    = rs_reg;
    assign q_data.data  = chr_reg[0];
    assign q_data.last  = (cnt_reg == 3'd1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        steps_next = steps_reg;
        val_next   = val_reg;
        hex_next   = hex_reg;
        sign_next  = sign_reg;
        neg_next   = neg_reg;
        init_next  = init_reg;
        rs_next    = rs_reg;
        for (int i = 0; i < SLOTS; i++)
        begin
            chr_next[i] = chr_reg[i];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_CONV:
            begin
                for (int i = 1; i < SLOTS; i++)
                begin
                    chr_next[i] = chr_reg[i-1];
                end
                chr_next[0] = conv_char;
                cnt_next    = cnt_reg + 3'd1;
                val_next    = conv_val;
                steps_next  = steps_reg - 3'd1;
                if (steps_reg == 3'd1)
                begin
                    state_next = sign_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                for (int i = 1; i < SLOTS; i++)
                begin
                    chr_next[i] = chr_reg[i-1];
                end
                chr_next[0] = neg_reg ? clnw_pkg::CHAR_MINUS : clnw_pkg::CHAR_SPACE;
                cnt_next    = cnt_reg + 3'd1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (q_ready)
                begin
                    for (int i = 0; i < SLOTS - 1; i++)
                    begin
                        chr_next[i] = chr_reg[i+1];
                    end
                    cnt_next = cnt_reg - 3'd1;
                    if (cnt_reg == 3'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (take)
        begin
            init_next  = 1'b0;
            rs_next    = 1'b1;
            hex_next   = 1'b0;
            sign_next  = 1'b0;
            neg_next   = cmds.value[15];
            val_next   = cmds.value;
            cnt_next   = 3'd1;
            steps_next = 3'd5;
            unique case (cmds.cmd)
                clnw_pkg::CMD_INIT:
                begin
                    init_next  = 1'b1;
                    rs_next    = 1'b0;
                    state_next = ST_EMIT;
                end
                clnw_pkg::CMD_INSTR:
                begin
                    rs_next     = 1'b0;
                    chr_next[0] = cmds.value[7:0];
                    state_next  = ST_EMIT;
                end
                clnw_pkg::CMD_CHAR:
                begin
                    chr_next[0] = cmds.value[7:0];
                    state_next  = ST_EMIT;
                end
                clnw_pkg::CMD_CURSOR:
                begin
                    rs_next     = 1'b0;
                    chr_next[0] = clnw_pkg::CURSOR_BASE | {1'b0, cursor_addr};
                    state_next  = ST_EMIT;
                end
                clnw_pkg::CMD_UDEC:
                begin
                    cnt_next   = 3'd0;
                    state_next = ST_CONV;
                end
                clnw_pkg::CMD_SDEC:
                begin
                    cnt_next  = 3'd0;
                    sign_next = 1'b1;
                    if (cmds.value[15])
                    begin
                        val_next = 16'd0 - cmds.value;
                    end
                    state_next = ST_CONV;
                end
                clnw_pkg::CMD_HEX:
                begin
                    cnt_next   = 3'd0;
                    hex_next   = 1'b1;
                    steps_next = 3'd4;
                    state_next = ST_CONV;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 3'd0;
            steps_reg <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        hex_reg  <= hex_next;
        sign_reg <= sign_next;
        neg_reg  <= neg_next;
        init_reg <= init_next;
        rs_reg   <= rs_next;
        for (int i = 0; i < SLOTS; i++)
        begin
            chr_reg[i] <= chr_next[i];
        end
    end

    `ASSERT_NEVER(a_front_emit_count, (state_reg == ST_EMIT) && ((cnt_reg == 3'd0) || (cnt_reg > 3'd6)), "front emits with no word buffered")

endmodule

FILE: rtl/core/clnw_queue.sv
`include "assert_macros.svh"

module clnw_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  clnw_pkg::clnw_entry_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output clnw_pkg::clnw_entry_t pop_data
);

    localparam int AW = clnw_pkg::QUEUE_AW;
    localparam logic [AW:0] FULL_COUNT = (AW + 1)'(clnw_pkg::QUEUE_DEPTH);

    clnw_pkg::clnw_entry_t mem [clnw_pkg::QUEUE_DEPTH];

    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_queue_count, count_reg > FULL_COUNT, "queue fill count beyond its depth")
    `ASSERT_HOLDS(a_queue_ptrs, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "empty queue with pointers apart")

endmodule

FILE: rtl/core/clnw_back.sv
`include "assert_macros.svh"

module clnw_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  clnw_pkg::clnw_entry_t pop_data,
    clnw_xfer_if.source           xfers
);

    logic                  cur_valid_reg;
    clnw_pkg::clnw_entry_t cur_reg;
    logic [3:0]            step_reg;
    logic                  out_valid_reg;
    clnw_pkg::clnw_xfer_t  out_reg;

    clnw_pkg::clnw_xfer_t  res;
    logic                  advance;
    logic                  fire;
    logic                  final_step;

    assign advance    = !out_valid_reg || xfers.ready;
    assign fire       = cur_valid_reg && advance;
    assign final_step = cur_reg.init ? (step_reg == clnw_pkg::INIT_STEP_LAST) : (step_reg == 4'd1);
    assign pop_ready  = !cur_valid_reg || (fire && final_step);

    always_comb
    begin
        if (cur_reg.init)
        begin
            res = clnw_pkg::init_step(step_reg);
        end
        else
        begin
            res.kind          = 1'b0;
            res.reg_select    = cur_reg.rs;
            res.nibble        = step_reg[0] ? cur_reg.data[3:0] : cur_reg.data[7:4];
            res.wait_after_us = step_reg[0] ? clnw_pkg::BYTE_WAIT_US : 15'd0;
            res.last          = 1'b0;
        end
        res.last = final_step && cur_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= 4'd0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= cur_valid_reg;
            end
            if (pop_ready)
            begin
                cur_valid_reg <= pop_valid;
                step_reg      <= 4'd0;
            end
            else if (fire)
            begin
                step_reg <= step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= res;
        end
        if (pop_ready)
        begin
            cur_reg <= pop_data;
        end
    end

    assign xfers.valid         = out_valid_reg;
    assign xfers.kind          = out_reg.kind;
    assign xfers.reg_select    = out_reg.reg_select;
    assign xfers.nibble        = out_reg.nibble;
    assign xfers.wait_after_us = out_reg.wait_after_us;
    assign xfers.last          = out_reg.last;

    `ASSERT_NEVER(a_back_byte_step, cur_valid_reg && !cur_reg.init && (step_reg > 4'd1), "byte word beyond its second nibble")
    `ASSERT_HOLDS(a_back_last_ends, (fire && res.last) |=> (!cur_valid_reg || (step_reg == 4'd0)), "run did not end after its last transfer")

endmodule

FILE: rtl/core/char_lcd_nibble_write_engine.sv
// A command's first transfer passes through the front end's state register, the queue and
// the back end's word and result registers; decimal, signed decimal and hex are converted first.
// One transfer per cycle at the output while work is queued and xfers.ready is high, paced by
// the back end's single result register; a command has 2 transfers per byte, 15 for power-on.
// Decimal and hex digits are formed one per cycle in the front end, overlapping earlier output.
// Reset (rst_n, asynchronous, active low) empties the queue and all pending work.
module char_lcd_nibble_write_engine (
    input  logic        clk,
    input  logic        rst_n,
    clnw_cmd_if.sink    cmds,
    clnw_xfer_if.source xfers
);

    logic                  push_valid;
    logic                  push_ready;
    clnw_pkg::clnw_entry_t push_data;
    logic                  pop_valid;
    logic                  pop_ready;
    clnw_pkg::clnw_entry_t pop_data;

    clnw_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmds    (cmds),
        .q_valid (push_valid),
        .q_ready (push_ready),
        .q_data  (push_data)
    );

    clnw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    clnw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .xfers     (xfers)
    );

endmodule

FILE: tb/char_lcd_nibble_write_engine_monitor.sv
module char_lcd_nibble_write_engine_monitor
(
    input  logic clk,
    input  logic rst_n,
    clnw_cmd_if  cmds,
    clnw_xfer_if xfers,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    clnw_pkg::clnw_xfer_t expected_xfers[$];
    int                   fails = 0;

    function automatic void queue_xfer(input logic kind, input logic rs,
                                       input logic [3:0] nib, input logic [14:0] wait_us);
        clnw_pkg::clnw_xfer_t x;
        x.kind          = kind;
        x.reg_select    = rs;
        x.nibble        = nib;
        x.wait_after_us = wait_us;
        x.last          = 1'b0;
        expected_xfers.push_back(x);
    endfunction

    function automatic void queue_byte(input logic rs, input logic [7:0] b,
                                       input logic [14:0] extra_us);
        queue_xfer(1'b0, rs, b[7:4], 15'd0);
        queue_xfer(1'b0, rs, b[3:0], clnw_pkg::BYTE_WAIT_US + extra_us);
    endfunction

    function automatic void queue_decimal(input logic [15:0] v);
        int unsigned n;
        n = v;
        for (int unsigned div = 10000; div > 0; div = div / 10)
        begin
            queue_byte(1'b1, 8'(32'h30 + (n / div) % 10), 15'd0);
        end
    endfunction

    function automatic void predict_command(input logic [2:0] cmd, input logic [15:0] value,
                                            input logic row, input logic [5:0] col);
        int                   first;
        logic [3:0]           d;
        clnw_pkg::clnw_xfer_t tail;
        first = expected_xfers.size();
        case (cmd)
            clnw_pkg::CMD_INIT:
            begin
                queue_xfer(1'b1, 1'b1, 4'hF, 15'd20000);
                queue_xfer(1'b0, 1'b0, 4'h3, 15'd15000);
                queue_xfer(1'b0, 1'b0, 4'h3, 15'd5000);
                queue_xfer(1'b0, 1'b0, 4'h3, 15'd5000);
                queue_xfer(1'b0, 1'b0, 4'h2, 15'd5000);
                queue_byte(1'b0, 8'h28, 15'd1000);
                queue_byte(1'b0, 8'h0C, 15'd1000);
                queue_byte(1'b0, 8'h06, 15'd1000);
                queue_byte(1'b0, 8'h01, 15'd2000);
                queue_byte(1'b0, clnw_pkg::CURSOR_BASE, 15'd2000);
            end
            clnw_pkg::CMD_INSTR:
            begin
                queue_byte(1'b0, value[7:0], 15'd0);
            end
            clnw_pkg::CMD_CHAR:
            begin
                queue_byte(1'b1, value[7:0], 15'd0);
            end
            clnw_pkg::CMD_CURSOR:
            begin
                queue_byte(1'b0, clnw_pkg::CURSOR_BASE | (8'({row, 6'b0}) + 8'(col)), 15'd0);
            end
            clnw_pkg::CMD_UDEC:
            begin
                queue_decimal(value);
            end
            clnw_pkg::CMD_SDEC:
            begin
                if (value[15])
                begin
                    queue_byte(1'b1, clnw_pkg::CHAR_MINUS, 15'd0);
                    queue_decimal(~value + 16'd1);
                end
                else
                begin
                    queue_byte(1'b1, clnw_pkg::CHAR_SPACE, 15'd0);
                    queue_decimal(value);
                end
            end
            clnw_pkg::CMD_HEX:
            begin
                for (int i = 3; i >= 0; i--)
                begin
                    d = value[i*4 +: 4];
                    queue_byte(1'b1, (d < 4'd10) ? 8'd48 + 8'(d) : 8'd55 + 8'(d), 15'd0);
                end
            end
            default:
            begin
            end
        endcase
        if (expected_xfers.size() > first)
        begin
            tail = expected_xfers.pop_back();
            tail.last = 1'b1;
            expected_xfers.push_back(tail);
        end
    endfunction

    function automatic void compare_field(input string field, input int unsigned want_v,
                                          input int unsigned got_v);
        if (want_v != got_v)
        begin
            fails++;
            $display("%0t: %s expected %0h actual %0h", $time, field, want_v, got_v);
        end
    endfunction

    always @(posedge clk)
    begin
        clnw_pkg::clnw_xfer_t got;
        clnw_pkg::clnw_xfer_t want;
        if (rst_n)
        begin
            if (xfers.valid && xfers.ready)
            begin
                got.kind          = xfers.kind;
                got.reg_select    = xfers.reg_select;
                got.nibble        = xfers.nibble;
                got.wait_after_us = xfers.wait_after_us;
                got.last          = xfers.last;
                if (expected_xfers.size() == 0)
                begin
                    fails++;
                    $display("%0t: word expected none actual %p", $time, got);
                end
                else
                begin
                    want = expected_xfers.pop_front();
                    compare_field("kind", want.kind, got.kind);
                    compare_field("reg_select", want.reg_select, got.reg_select);
                    compare_field("nibble", want.nibble, got.nibble);
                    compare_field("wait_after_us", want.wait_after_us, got.wait_after_us);
                    compare_field("last", want.last, got.last);
                end
            end
            if (cmds.valid && cmds.ready)
            begin
                predict_command(cmds.cmd, cmds.value, cmds.row, cmds.col);
            end
        end
        pending    <= expected_xfers.size();
        fail_count <= fails;
    end

endmodule

FILE: tb/char_lcd_nibble_write_engine_tb.sv
module char_lcd_nibble_write_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_UNUSED   = 3'd7;
    localparam int         RANDOM_WORDS = 400;
    localparam int         TAIL_CYCLES  = 40;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   stall_cycle = 0;
    int   stall_mode  = 0;

    clnw_cmd_if  cmd_bus();
    clnw_xfer_if xfer_bus();

    char_lcd_nibble_write_engine dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmds  (cmd_bus),
        .xfers (xfer_bus)
    );

    char_lcd_nibble_write_engine_monitor xfer_monitor
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmds       (cmd_bus),
        .xfers      (xfer_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 97 == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
        end
        if (!rst_n)
        begin
            xfer_bus.ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       xfer_bus.ready <= 1'b1;
                1:       xfer_bus.ready <= ($urandom_range(0, 2) != 0);
                2:       xfer_bus.ready <= ((stall_cycle % 7) >= 3);
                default: xfer_bus.ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    task automatic send_word(input logic [2:0] c, input logic [15:0] v,
                             input logic r, input logic [5:0] k);
        cmd_bus.valid <= 1'b1;
        cmd_bus.cmd   <= c;
        cmd_bus.value <= v;
        cmd_bus.row   <= r;
        cmd_bus.col   <= k;
        @(posedge clk);
        while (!cmd_bus.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            cmd_bus.valid <= 1'b0;
            cmd_bus.cmd   <= 3'($urandom);
            cmd_bus.value <= 16'($urandom);
            cmd_bus.row   <= 1'($urandom);
            cmd_bus.col   <= 6'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h0000;
            1:       v = 16'hFFFF;
            2:       v = 16'h8000;
            3:       v = 16'h7FFF;
            4:       v = 16'($urandom_range(0, 20));
            5:       v = 16'($urandom_range(9990, 10010));
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    initial
    begin
        int         sent;
        int         burst;
        int         roll;
        logic [2:0] c;
        logic [5:0] k;
        cmd_bus.valid  <= 1'b0;
        cmd_bus.cmd    <= clnw_pkg::CMD_INIT;
        cmd_bus.value  <= 16'h0000;
        cmd_bus.row    <= 1'b0;
        cmd_bus.col    <= 6'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(clnw_pkg::CMD_INIT, 16'h0000, 1'b0, 6'd0);
        send_word(clnw_pkg::CMD_INSTR, 16'h0000, 1'b0, 6'd0);
        send_word(clnw_pkg::CMD_INSTR, 16'hFFFF, 1'b1, 6'd63);
        send_word(clnw_pkg::CMD_CHAR, 16'hFF00, 1'b0, 6'd0);
        send_word(clnw_pkg::CMD_CHAR, 16'h00FF, 1'b1, 6'd63);
        idle_cycles(3);
        send_word(clnw_pkg::CMD_CURSOR, 16'h0000, 1'b0, 6'd0);
        send_word(clnw_pkg::CMD_CURSOR, 16'hFFFF, 1'b1, 6'd39);
        send_word(clnw_pkg::CMD_CURSOR, 16'h0000, 1'b1, 6'd63);
        send_word(clnw_pkg::CMD_UDEC, 16'd0, 1'b0, 6'd0);
        send_word(clnw_pkg::CMD_UDEC, 16'd65535, 1'b0, 6'd0);
        send_word(clnw_pkg::CMD_UDEC, 16'd12345, 1'b0, 6'd0);
        send_word(clnw_pkg::CMD_SDEC, 16'd0, 1'b0, 6'd0);
        send_word(clnw_pkg::CMD_SDEC, 16'h7FFF, 1'b0, 6'd0);
        send_word(clnw_pkg::CMD_SDEC, 16'h8000, 1'b0, 6'd0);
        send_word(clnw_pkg::CMD_SDEC, 16'hFFFF, 1'b0, 6'd0);
        send_word(clnw_pkg::CMD_SDEC, 16'd1, 1'b0, 6'd0);
        send_word(clnw_pkg::CMD_HEX, 16'h0000, 1'b0, 6'd0);
        send_word(clnw_pkg::CMD_HEX, 16'hFFFF, 1'b0, 6'd0);
        send_word(clnw_pkg::CMD_HEX, 16'h1A2F, 1'b0, 6'd0);
        send_word(CMD_UNUSED, 16'hFFFF, 1'b1, 6'd63);
        send_word(clnw_pkg::CMD_INSTR, 16'h0055, 1'b0, 6'd0);
        drain();

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                begin
                    c = clnw_pkg::CMD_INIT;
                end
                else if (roll < 9)
                begin
                    c = CMD_UNUSED;
                end
                else
                begin
                    c = 3'($urandom_range(1, 6));
                end
                k = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63))
                                                 : 6'($urandom_range(0, 39));
                send_word(c, pick_value(), 1'($urandom), k);
                if (c != CMD_UNUSED)
                begin
                    sent++;
                end
            end
            if (sent >= RANDOM_WORDS / 2 && sent < RANDOM_WORDS / 2 + burst)
            begin
                drain();
            end
            else if ($urandom_range(0, 9) < 7)
            begin
                idle_cycles($urandom_range(1, 5));
            end
        end

        drain();
        if (fail_count == 0 && pending == 0)
        begin
            $display("PASS char_lcd_nibble_write_engine");
        end
        else
        begin
            $display("FAIL char_lcd_nibble_write_engine");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAIL char_lcd_nibble_write_engine");
        $finish;
    end

endmodule
